/* rtl/core/lup_pkg.sv */
// Shared constants, types and the Lanczos weight tables of the line upscaler.
package lup_pkg;

    localparam int LUP_SCALE_DEF = 2;
    localparam int LUP_HALF_DEF  = 3;
    localparam int LUP_PIX_W     = 8;
    localparam int LUP_FRAC_W    = 14;
    localparam int LUP_W_W       = 16;
    localparam int LUP_PROD_W    = LUP_PIX_W + 1 + LUP_W_W;
    localparam int LUP_TAB_LEN   = 37;
    localparam int LUP_IDX_W     = 7;
    localparam int LUP_PIX_MAX   = 255;

    typedef logic signed [LUP_W_W-1:0] lup_weight_t;

    // Q2.14 weights indexed by twelve times the distance
    localparam lup_weight_t LUP_W_A2 [LUP_TAB_LEN] = '{
        16384, 0, 0, 14375, 12939, 0, 9391, 0, 5603, 3856, 0, 0,
        0, 0, 0, -1388, -1401, 0, -1043, 0, -518, -293, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };
    localparam lup_weight_t LUP_W_A3 [LUP_TAB_LEN] = '{
        16384, 0, 0, 14583, 13276, 0, 9960, 0, 6238, 4427, 0, 0,
        0, 0, 0, -2177, -2389, 0, -2213, 0, -1529, -1111, 0, 0,
        0, 0, 0, 492, 509, 0, 398, 0, 207, 121, 0, 0, 0
    };

    // Job tag carried from the sequencer to the multiply stage
    typedef struct packed {
        logic last_line;
        logic run_last;
        logic row_end;
    } lup_tag_t;

    // Control carried from the multiply stage to the output stage
    typedef struct packed {
        logic min_en;
        logic max_en;
        logic run_last;
        logic row_end;
    } lup_flags_t;

    function automatic lup_weight_t lup_weight(input int half, input logic [LUP_IDX_W-1:0] idx);
        lup_weight_t w;
        w = '0;
        if (idx < LUP_IDX_W'(LUP_TAB_LEN))
        begin
            if (half == 2)
            begin
                w = LUP_W_A2[idx[5:0]];
            end
            else
            begin
                w = LUP_W_A3[idx[5:0]];
            end
        end
        return w;
    endfunction

endpackage

/* rtl/core/lanczos_line_upscaler_unit.sv */
// Lanczos line upscaler: top level joining sequencer, multiply and output stages.
//
//  channel   dir  tdata        tlast      tuser
//  s_axis    in   in_pixel     row_last   -
//  m_axis    out  out_pixel    row_end    run_last
//
// One result leaves per cycle unless m_axis stalls, taken from the job register
// one phase at a time: SCALE_FACTOR per pixel, (min(position, HALF_TAPS) + 1) *
// SCALE_FACTOR for a line's last pixel, none for its first HALF_TAPS but the last.
// A beat passes the job, multiply and output registers before its first result.
// Reset clears the window, the line position and every valid flag.
// A stall on m_axis freezes the multiply and output stages and any pending job;
// s_axis is taken when no job is pending or in the cycle its last result moves on.
module lanczos_line_upscaler_unit #(
    parameter int SCALE_FACTOR = lup_pkg::LUP_SCALE_DEF,
    parameter int HALF_TAPS    = lup_pkg::LUP_HALF_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lup_pkg::LUP_PIX_W-1:0] s_axis_tdata,  // [7:0] in_pixel
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lup_pkg::LUP_PIX_W-1:0] m_axis_tdata,  // [7:0] out_pixel
    output logic                          m_axis_tlast,
    output logic [0:0]                    m_axis_tuser   // [0] run_last
);
    import lup_pkg::*;

    localparam int WIN = 2 * HALF_TAPS;
    localparam int JW  = $clog2(HALF_TAPS + 1);
    localparam int PW  = $clog2(SCALE_FACTOR);
    localparam int NW  = $clog2(WIN + 1);

    logic                          advance;
    logic                          job_valid;
    logic [WIN-1:0][LUP_PIX_W-1:0] job_win;
    logic [JW-1:0]                 job_j;
    logic [PW-1:0]                 job_p;
    logic [NW-1:0]                 job_n;
    lup_tag_t                      job_tag;
    logic                          prod_valid;
    logic [WIN-1:0][LUP_PROD_W-1:0] prod;
    logic [LUP_PIX_W-1:0]          bound_min, bound_max;
    lup_flags_t                    flags;
    logic                          run_last;

    // Advance every stage whenever the output register is free or being taken
    assign advance = !m_axis_tvalid || m_axis_tready;

    lup_seq #(
        .SCALE_FACTOR (SCALE_FACTOR),
        .HALF_TAPS    (HALF_TAPS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pixel  (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .advance   (advance),
        .job_valid (job_valid),
        .job_win   (job_win),
        .job_j     (job_j),
        .job_p     (job_p),
        .job_n     (job_n),
        .job_tag   (job_tag)
    );

    lup_mult #(
        .SCALE_FACTOR (SCALE_FACTOR),
        .HALF_TAPS    (HALF_TAPS)
    ) u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .job_valid  (job_valid),
        .job_win    (job_win),
        .job_j      (job_j),
        .job_p      (job_p),
        .job_n      (job_n),
        .job_tag    (job_tag),
        .prod_valid (prod_valid),
        .prod       (prod),
        .bound_min  (bound_min),
        .bound_max  (bound_max),
        .flags      (flags)
    );

    lup_post #(
        .HALF_TAPS (HALF_TAPS)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .prod_valid (prod_valid),
        .prod       (prod),
        .bound_min  (bound_min),
        .bound_max  (bound_max),
        .flags      (flags),
        .out_valid  (m_axis_tvalid),
        .out_pixel  (m_axis_tdata),
        .row_end    (m_axis_tlast),
        .run_last   (run_last)
    );

    assign m_axis_tuser = run_last;

`ifndef NO_ASSERTIONS
    // The input side only waits behind a pending job
    a_ready_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> job_valid)
        else $error("s_axis_tready low with no job pending");

    // The end of a line always closes a run
    a_row_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("row end without run end");

    // A line end always leaves a job behind
    a_last_makes_job: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> job_valid)
        else $error("line end beat produced no job");

    // A stalled output freezes the multiply stage
    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && prod_valid |=> prod_valid)
        else $error("multiply stage lost a result during a stall");
`endif

endmodule

/* rtl/core/lup_seq.sv */
// Pixel window, line position and output job sequencer.
module lup_seq #(
    parameter int SCALE_FACTOR = lup_pkg::LUP_SCALE_DEF,
    parameter int HALF_TAPS    = lup_pkg::LUP_HALF_DEF,
    localparam int WIN = 2 * HALF_TAPS,
    localparam int JW  = $clog2(HALF_TAPS + 1),
    localparam int PW  = $clog2(SCALE_FACTOR),
    localparam int NW  = $clog2(WIN + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lup_pkg::LUP_PIX_W-1:0]       in_pixel,
    input  logic                                in_last,
    input  logic                                advance,
    output logic                                job_valid,
    output logic [WIN-1:0][lup_pkg::LUP_PIX_W-1:0] job_win,
    output logic [JW-1:0]                       job_j,
    output logic [PW-1:0]                       job_p,
    output logic [NW-1:0]                       job_n,
    output lup_pkg::lup_tag_t                   job_tag
);
    import lup_pkg::*;

    logic [WIN-1:0][LUP_PIX_W-1:0] win_reg, win_next;
    logic [NW-1:0]                 pos_reg, pos_next;
    logic                          job_valid_reg;
    logic [WIN-1:0][LUP_PIX_W-1:0] jwin_reg;
    logic [NW-1:0]                 jn_reg;
    logic                          jlast_reg;
    logic [JW-1:0]                 j_reg, jbot_reg;
    logic [PW-1:0]                 p_reg;
    logic                          final_beat, accept, has_job;
    logic [JW-1:0]                 jtop, jbot;

    assign final_beat = (j_reg == jbot_reg) && (p_reg == PW'(SCALE_FACTOR - 1));
    assign in_ready   = !job_valid_reg || (final_beat && advance);
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        win_next = {win_reg[WIN-2:0], in_pixel};
        if (in_last)
        begin
            pos_next = '0;
        end
        else if (pos_reg < NW'(WIN))
        begin
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
        has_job = in_last || (pos_reg >= NW'(HALF_TAPS));
        if (in_last)
        begin
            jtop = (pos_reg < NW'(HALF_TAPS)) ? JW'(pos_reg) : JW'(HALF_TAPS);
            jbot = '0;
        end
        else
        begin
            jtop = JW'(HALF_TAPS);
            jbot = JW'(HALF_TAPS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            pos_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                win_reg       <= win_next;
                pos_reg       <= pos_next;
                job_valid_reg <= has_job;
            end
            else if (advance && job_valid_reg && final_beat)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    // Job payload: load on a new line position, else step phase then position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            jwin_reg  <= win_next;
            jn_reg    <= pos_reg;
            jlast_reg <= in_last;
            j_reg     <= jtop;
            jbot_reg  <= jbot;
            p_reg     <= '0;
        end
        else if (advance && job_valid_reg && !final_beat)
        begin
            if (p_reg == PW'(SCALE_FACTOR - 1))
            begin
                p_reg <= '0;
                j_reg <= j_reg - 1'b1;
            end
            else
            begin
                p_reg <= p_reg + 1'b1;
            end
        end
    end

    assign job_valid          = job_valid_reg;
    assign job_win            = jwin_reg;
    assign job_j              = j_reg;
    assign job_p              = p_reg;
    assign job_n              = jn_reg;
    assign job_tag.last_line  = jlast_reg;
    assign job_tag.run_last   = final_beat;
    assign job_tag.row_end    = final_beat && jlast_reg;

endmodule

/* rtl/core/lup_mult.sv */
// Weight lookup, tap products and clamp bounds, registered.
module lup_mult #(
    parameter int SCALE_FACTOR = lup_pkg::LUP_SCALE_DEF,
    parameter int HALF_TAPS    = lup_pkg::LUP_HALF_DEF,
    localparam int WIN = 2 * HALF_TAPS,
    localparam int JW  = $clog2(HALF_TAPS + 1),
    localparam int PW  = $clog2(SCALE_FACTOR),
    localparam int NW  = $clog2(WIN + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   job_valid,
    input  logic [WIN-1:0][lup_pkg::LUP_PIX_W-1:0] job_win,
    input  logic [JW-1:0]                          job_j,
    input  logic [PW-1:0]                          job_p,
    input  logic [NW-1:0]                          job_n,
    input  lup_pkg::lup_tag_t                      job_tag,
    output logic                                   prod_valid,
    output logic [WIN-1:0][lup_pkg::LUP_PROD_W-1:0] prod,
    output logic [lup_pkg::LUP_PIX_W-1:0]          bound_min,
    output logic [lup_pkg::LUP_PIX_W-1:0]          bound_max,
    output lup_pkg::lup_flags_t                    flags
);
    import lup_pkg::*;

    localparam int STEP = 12 / SCALE_FACTOR;

    logic                            valid_reg;
    logic [WIN-1:0][LUP_PROD_W-1:0]  prod_reg, prod_next;
    logic [LUP_PIX_W-1:0]            min_reg, max_reg, min_next, max_next;
    lup_flags_t                      flags_reg, flags_next;
    logic [HALF_TAPS:0][LUP_PIX_W-1:0] lane_min, lane_max;

    // Per centre position bounds over itself and its two neighbours
    always_comb
    begin
        lane_min = '0;
        lane_max = '0;
        for (int c = 1; c <= HALF_TAPS; c++)
        begin
            logic [LUP_PIX_W-1:0] a, b, d, m, x;
            a = job_win[c+1];
            b = job_win[c];
            d = job_win[c-1];
            m = (a < b) ? a : b;
            m = (m < d) ? m : d;
            x = (a > b) ? a : b;
            x = (x > d) ? x : d;
            lane_min[c] = m;
            lane_max[c] = x;
        end
    end

    always_comb
    begin
        for (int k = 0; k < WIN; k++)
        begin
            logic [7:0]                    pos, neg, tap_dist;
            lup_weight_t                   w;
            logic signed [LUP_PIX_W:0]     pix;
            logic                          tap_en;
            pos      = 8'(12 * k) + 8'(job_p) * 8'(STEP);
            neg      = 8'(job_j) * 8'd12;
            tap_dist = (pos >= neg) ? (pos - neg) : (neg - pos);
            tap_en   = (k <= int'(job_j) + HALF_TAPS - 1) && (k <= int'(job_n));
            w        = tap_en ? lup_weight(HALF_TAPS, tap_dist[LUP_IDX_W-1:0]) : '0;
            pix      = $signed({1'b0, job_win[k]});
            prod_next[k] = LUP_PROD_W'(pix) * LUP_PROD_W'(w);
        end
        min_next = lane_min[job_j];
        max_next = lane_max[job_j];
        flags_next.min_en   = (job_j != '0) && (int'(job_n) >= int'(job_j) + 2);
        flags_next.max_en   = (!job_tag.last_line || (int'(job_j) >= 2)) && (job_j != '0)
                              && (int'(job_n) >= int'(job_j) + 1);
        flags_next.run_last = job_tag.run_last;
        flags_next.row_end  = job_tag.row_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg  <= prod_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            flags_reg <= flags_next;
        end
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;
    assign bound_min  = min_reg;
    assign bound_max  = max_reg;
    assign flags      = flags_reg;

endmodule

/* rtl/core/lup_post.sv */
// Tap sum, neighbour clamp, saturation and the output register.
module lup_post #(
    parameter int HALF_TAPS = lup_pkg::LUP_HALF_DEF,
    localparam int WIN   = 2 * HALF_TAPS,
    localparam int ACC_W = lup_pkg::LUP_PROD_W + $clog2(WIN) + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    advance,
    input  logic                                    prod_valid,
    input  logic [WIN-1:0][lup_pkg::LUP_PROD_W-1:0] prod,
    input  logic [lup_pkg::LUP_PIX_W-1:0]           bound_min,
    input  logic [lup_pkg::LUP_PIX_W-1:0]           bound_max,
    input  lup_pkg::lup_flags_t                     flags,
    output logic                                    out_valid,
    output logic [lup_pkg::LUP_PIX_W-1:0]           out_pixel,
    output logic                                    row_end,
    output logic                                    run_last
);
    import lup_pkg::*;

    logic                     valid_reg;
    logic [LUP_PIX_W-1:0]     pix_reg, pix_next;
    logic                     row_end_reg, run_last_reg;
    logic signed [ACC_W-1:0]  acc, lo, hi, whole;

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < WIN; k++)
        begin
            acc = acc + ACC_W'($signed(prod[k]));
        end
        lo = $signed(ACC_W'({bound_min, {LUP_FRAC_W{1'b0}}}));
        hi = $signed(ACC_W'({bound_max, {LUP_FRAC_W{1'b0}}}));
        if (flags.min_en && (acc < lo))
        begin
            acc = lo;
        end
        if (flags.max_en && (acc > hi))
        begin
            acc = hi;
        end
        whole = acc >>> LUP_FRAC_W;
        if (acc < 0)
        begin
            pix_next = '0;
        end
        else if (whole > ACC_W'(LUP_PIX_MAX))
        begin
            pix_next = LUP_PIX_W'(LUP_PIX_MAX);
        end
        else
        begin
            pix_next = whole[LUP_PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg      <= pix_next;
            row_end_reg  <= flags.row_end;
            run_last_reg <= flags.run_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pix_reg;
    assign row_end   = row_end_reg;
    assign run_last  = run_last_reg;

endmodule

/* sim/lanczos_line_upscaler_checker.sv */
// Predicts and checks the upscaled pixel stream of the Lanczos line upscaler.
`timescale 1ns / 100ps

module lanczos_line_upscaler_checker #(
    parameter int SCALE_FACTOR = lup_pkg::LUP_SCALE_DEF,
    parameter int HALF_TAPS    = lup_pkg::LUP_HALF_DEF,
    parameter int MAX_LINE     = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [lup_pkg::LUP_PIX_W-1:0] s_axis_tdata,  // [7:0] in_pixel
    input  logic                          s_axis_tlast,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [lup_pkg::LUP_PIX_W-1:0] m_axis_tdata,  // [7:0] out_pixel
    input  logic                          m_axis_tlast,
    input  logic [0:0]                    m_axis_tuser,  // [0] run_last
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);

    localparam int WIN_LEN = 2 * HALF_TAPS;
    localparam int ONE_Q14 = 1 << lup_pkg::LUP_FRAC_W;

    typedef struct packed {
        logic [lup_pkg::LUP_PIX_W-1:0] pixel;
        logic                          row_end;
        logic                          run_last;
    } out_beat_t;

    logic [lup_pkg::LUP_PIX_W-1:0] win [WIN_LEN];  // newest pixel first
    int                            line_pos;
    out_beat_t                     upscaled_q [$];
    out_beat_t                     want;
    out_beat_t                     got;
    int                            errs;
    int                            n_checked;

    function automatic int tap_weight(int idx);
        int a;
        a = (idx < 0) ? -idx : idx;
        if (a >= lup_pkg::LUP_TAB_LEN)
            return 0;
        if (HALF_TAPS == 2)
            return int'(lup_pkg::LUP_W_A2[a]);
        return int'(lup_pkg::LUP_W_A3[a]);
    endfunction

    // Output for position n-j at phase p, n being the index of the newest pixel
    function automatic logic [7:0] interp_pixel(int n, int j, int p, bit last);
        int acc;
        int kmax;
        int lo;
        int hi;
        acc  = 0;
        kmax = j + HALF_TAPS - 1;
        if (kmax > n)
            kmax = n;
        if (kmax > WIN_LEN - 1)
            kmax = WIN_LEN - 1;
        for (int k = 0; k <= kmax; k++)
            acc += int'(win[k]) * tap_weight(12 * (k - j) + (12 * p) / SCALE_FACTOR);
        if (j >= 1 && j + 1 < WIN_LEN)
        begin
            lo = int'(win[j + 1]);
            hi = lo;
            for (int k = j - 1; k <= j; k++)
            begin
                if (int'(win[k]) < lo)
                    lo = int'(win[k]);
                if (int'(win[k]) > hi)
                    hi = int'(win[k]);
            end
            // min clamp needs the right neighbour inside the line
            if (n >= j + 2 && acc < lo * ONE_Q14)
                acc = lo * ONE_Q14;
            if ((!last || j >= 2) && n >= j + 1 && acc > hi * ONE_Q14)
                acc = hi * ONE_Q14;
        end
        if (acc < 0)
            return 8'd0;
        acc = acc / ONE_Q14;
        return (acc > lup_pkg::LUP_PIX_MAX) ? 8'd255 : acc[7:0];
    endfunction

    function automatic void predict_pixel(logic [7:0] pix, logic last);
        int        n;
        int        jtop;
        int        jbot;
        out_beat_t b;
        n = line_pos;
        for (int k = WIN_LEN - 1; k > 0; k--)
            win[k] = win[k - 1];
        win[0] = pix;
        if (last)
        begin
            jtop = (n < HALF_TAPS) ? n : HALF_TAPS;
            jbot = 0;
        end
        else if (n >= HALF_TAPS)
        begin
            jtop = HALF_TAPS;
            jbot = HALF_TAPS;
        end
        else
        begin
            jtop = -1;
            jbot = 0;
        end
        for (int j = jtop; j >= jbot; j--)
        begin
            for (int p = 0; p < SCALE_FACTOR; p++)
            begin
                b.pixel    = interp_pixel(n, j, p, last);
                b.run_last = (j == jbot && p == SCALE_FACTOR - 1);
                b.row_end  = last && b.run_last;
                upscaled_q.push_back(b);
            end
        end
        if (last)
            line_pos = 0;
        else if (line_pos < MAX_LINE - 1)
            line_pos++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_LEN; k++)
                win[k] = '0;
            line_pos = 0;
            upscaled_q.delete();
            errs       = 0;
            n_checked  = 0;
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pixel    = m_axis_tdata;
                got.row_end  = m_axis_tlast;
                got.run_last = m_axis_tuser[0];
                if (upscaled_q.size() == 0)
                begin
                    if (errs < 10)
                        $display("%0t: unexpected output beat: pixel %0d row_end %0b run_last %0b",
                                 $time, got.pixel, got.row_end, got.run_last);
                    errs++;
                end
                else
                begin
                    want = upscaled_q.pop_front();
                    n_checked++;
                    if (got.pixel !== want.pixel || got.row_end !== want.row_end
                        || got.run_last !== want.run_last)
                    begin
                        if (errs < 10)
                        begin
                            $display("%0t: beat %0d expected pixel %0d row_end %0b run_last %0b",
                                     $time, n_checked, want.pixel, want.row_end,
                                     want.run_last);
                            $display("%0t: beat %0d actual   pixel %0d row_end %0b run_last %0b",
                                     $time, n_checked, got.pixel, got.row_end, got.run_last);
                        end
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pixel(s_axis_tdata, s_axis_tlast);
            fail_count <= errs;
            pending    <= upscaled_q.size();
            checked    <= n_checked;
        end
    end

endmodule

/* sim/lanczos_line_upscaler_unit_tb.sv */
// Stimulus, idling and verdict for the Lanczos line upscaler testbench.
`timescale 1ns / 100ps

module lanczos_line_upscaler_unit_tb;

    localparam int SCALE_FACTOR   = 2;
    localparam int HALF_TAPS      = 3;
    localparam int MAX_LINE       = 1024;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_RAMP} pix_style_e;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [lup_pkg::LUP_PIX_W-1:0] s_axis_tdata;   // [7:0] in_pixel
    logic                          s_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [lup_pkg::LUP_PIX_W-1:0] m_axis_tdata;   // [7:0] out_pixel
    logic                          m_axis_tlast;
    logic [0:0]                    m_axis_tuser;   // [0] run_last

    int fail_count;
    int pending;
    int checked;

    int src_idle_pct;
    int sink_idle_pct;
    bit hold_req;
    bit hold_done;
    int pixels_sent;
    int lines_sent;
    int longest_line;
    int quiet_cycles;

    lanczos_line_upscaler_unit #(
        .SCALE_FACTOR(SCALE_FACTOR),
        .HALF_TAPS   (HALF_TAPS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    lanczos_line_upscaler_checker #(
        .SCALE_FACTOR(SCALE_FACTOR),
        .HALF_TAPS   (HALF_TAPS),
        .MAX_LINE    (MAX_LINE)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output side: random back-pressure, plus one long hold when requested
    initial
    begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= (int'($urandom_range(99)) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_pixel(input logic [7:0] pix, input logic last);
        if (int'($urandom_range(99)) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
    endtask

    // Black and white line: bit i of the mask sets pixel i to full scale
    task automatic send_mask_line(input int len, input logic [31:0] mask);
        for (int i = 0; i < len; i++)
            send_pixel(mask[i] ? 8'd255 : 8'd0, i == len - 1);
        lines_sent++;
    endtask

    task automatic send_line(input int len, input pix_style_e style);
        int v;
        v = int'($urandom_range(255));
        for (int i = 0; i < len; i++)
        begin
            case (style)
                PIX_UNIFORM: v = int'($urandom_range(255));
                PIX_EXTREME: v = $urandom_range(1) ? 255 : 0;
                default:
                begin
                    v = v + int'($urandom_range(40)) - 20;
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                end
            endcase
            send_pixel(v[7:0], i == len - 1);
        end
        lines_sent++;
        if (len > longest_line)
            longest_line = len;
    endtask

    // Whole lines until at least n_pix pixels have gone in
    task automatic send_random_lines(input int n_pix);
        int start;
        int len;
        int pick;
        start = pixels_sent;
        while (pixels_sent - start < n_pix)
        begin
            if ($urandom_range(9) < 7)
                len = int'($urandom_range(1, 12));
            else
                len = int'($urandom_range(13, 40));
            pick = int'($urandom_range(9));
            if (pick < 5)
                send_line(len, PIX_UNIFORM);
            else if (pick < 7)
                send_line(len, PIX_EXTREME);
            else
                send_line(len, PIX_RAMP);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        hold_req      = 1'b0;
        src_idle_pct  = 8;
        sink_idle_pct = 46;
        pixels_sent   = 0;
        lines_sent    = 0;
        longest_line  = 8;
        quiet_cycles  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short lines flush everything at their last pixel
        send_mask_line(1, 32'b1);
        send_mask_line(2, 32'b10);
        send_mask_line(3, 32'b101);
        // alternating full scale drives negative lobes and the clamps
        send_mask_line(8, 32'b10101010);
        // bright pair at the line start overshoots past 255
        send_mask_line(6, 32'b110011);
        send_mask_line(5, 32'b01000);

        send_random_lines(30);

        src_idle_pct  = 46;
        sink_idle_pct = 8;
        send_random_lines(40);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_lines(20);
        // keep offering while the output is held so the block backs up
        hold_req = 1'b1;
        send_line(24, PIX_UNIFORM);
        send_random_lines(15);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d pixels in %0d lines (longest %0d), checked %0d upscaled beats.",
                 pixels_sent, lines_sent, longest_line, checked);
        $display("Idling covered sender-heavy, receiver-heavy and none, plus a %0d-cycle hold.",
                 LONG_HOLD);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
